@@ design/drl_pkg.sv @@
// Package with widths, register indexes and shared types of the ratio limiter.
package drl_pkg;

    localparam int CMD_W      = 16;
    localparam int MAG_W      = CMD_W + 1;
    localparam int LIM_W      = 14;
    localparam int PROD_W     = 31;
    localparam int QUO_W      = 16;
    localparam int BIT_W      = 4;
    localparam int STEP_BITS  = 2;
    localparam int DIV_STAGES = QUO_W / STEP_BITS;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_MAG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MAG = 1'b1;

    localparam logic [LIM_W-1:0] MIN_MAG_RESET = 14'd0;
    localparam logic [LIM_W-1:0] MAX_MAG_RESET = 14'd12000;

    localparam logic [QUO_W:0] POS_LIMIT = 17'd32767;
    localparam logic [QUO_W:0] NEG_LIMIT = 17'd32768;

    typedef enum logic {
        OP_FLOOR   = 1'b0,
        OP_CEILING = 1'b1
    } t_op;

    // Fields that ride along unchanged to the output stage
    typedef struct packed {
        logic                    adj;
        logic                    pick_left;
        logic signed [CMD_W-1:0] fix;
        logic signed [CMD_W-1:0] left;
        logic signed [CMD_W-1:0] right;
    } t_pass;

    // Divisor is a full magnitude: a ceiling side of -32768 has magnitude 32768
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [MAG_W-1:0]  dvsr;
        logic [QUO_W-1:0]  quo;
        logic              ovf;
        logic              neg;
        t_pass             pass;
    } t_div_item;

    // One restoring step: try subtracting the divisor shifted to bit pos
    function automatic t_div_item div_step(t_div_item x, logic [BIT_W-1:0] pos);
        t_div_item   y;
        logic [31:0] trial;
        logic [31:0] cur;
        y     = x;
        trial = 32'(x.dvsr) << pos;
        cur   = 32'(x.rem);
        if (cur >= trial) begin
            y.rem      = PROD_W'(cur - trial);
            y.quo[pos] = 1'b1;
        end
        return y;
    endfunction

    function automatic logic [MAG_W-1:0] mag(logic signed [CMD_W-1:0] v);
        logic signed [MAG_W-1:0] w;
        w = MAG_W'(v);
        return v[CMD_W-1] ? MAG_W'(-w) : MAG_W'(w);
    endfunction

endpackage

@@ design/drl_ifs.sv @@
// Channel interfaces: command input, result output and register write port.
interface drl_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [drl_pkg::CMD_W-1:0]    left_in;
    logic signed [drl_pkg::CMD_W-1:0]    right_in;
    modport source (output valid, op, left_in, right_in, input ready);
    modport sink   (input valid, op, left_in, right_in, output ready);
endinterface

interface drl_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [drl_pkg::CMD_W-1:0]    left_out;
    logic signed [drl_pkg::CMD_W-1:0]    right_out;
    logic                                adjusted;
    modport source (output valid, left_out, right_out, adjusted, input ready);
    modport sink   (input valid, left_out, right_out, adjusted, output ready);
endinterface

interface drl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [drl_pkg::CFG_IDX_W-1:0]       index;
    logic [drl_pkg::LIM_W-1:0]           data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/drl_divider.sv @@
// Pipelined restoring divider with overflow detect, two quotient bits per stage.
module drl_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drl_pkg::t_div_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output drl_pkg::t_div_item  o_item
);

    localparam int N = drl_pkg::DIV_STAGES;

    logic               r_v    [0:N];
    drl_pkg::t_div_item r_item [0:N];
    logic               adv    [0:N];
    drl_pkg::t_div_item n_item [0:N];

    always_comb begin
        adv[N] = !r_v[N] || i_ready;
        for (int k = N - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    // Entry stage flags a quotient that will not fit in QUO_W bits
    always_comb begin
        n_item[0]     = i_item;
        n_item[0].quo = '0;
        n_item[0].ovf = {2'b0, i_item.rem} >= {i_item.dvsr, {drl_pkg::QUO_W{1'b0}}};
    end

    for (genvar k = 1; k <= N; k++) begin : g_step
        always_comb begin
            n_item[k] = r_item[k-1];
            for (int j = 0; j < drl_pkg::STEP_BITS; j++) begin
                n_item[k] = drl_pkg::div_step(n_item[k],
                    drl_pkg::BIT_W'(drl_pkg::QUO_W - 1 - drl_pkg::STEP_BITS * (k - 1) - j));
            end
        end
    end

    for (genvar k = 0; k <= N; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (adv[k]) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
            end
            if (adv[k]) begin
                r_item[k] <= n_item[k];
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[N];
    assign o_item  = r_item[N];

endmodule

@@ design/differential_drive_ratio_limiter.sv @@
// Top level of the differential drive ratio limiter.
// Takes one left/right command pair per cycle and returns one result per pair,
// in order, keeping the left-to-right ratio while the floor (op 0) or ceiling
// (op 1) moves one side to +/- the configured magnitude. Sustained rate is one
// pair per cycle when not stalled; the stages are decode, multiply, an overflow
// check, eight divide stages of two quotient bits each, and the output register.
// The 16-bit restoring divide sets the depth. Stalls back up stage by stage, so
// bubbles are absorbed and new pairs are taken while a result waits. Register
// writes complete in the cycle they are offered and belong between transactions.
module differential_drive_ratio_limiter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drl_cmd_if.sink    i_cmd,
    drl_res_if.source  o_res,
    drl_cfg_if.sink    i_cfg
);

    typedef struct packed {
        logic [drl_pkg::MAG_W-1:0] other_mag;
        logic [drl_pkg::MAG_W-1:0] side_mag;
        logic [drl_pkg::LIM_W-1:0] lim;
        logic                      neg;
        drl_pkg::t_pass            pass;
    } t_s1;

    typedef struct packed {
        logic signed [drl_pkg::CMD_W-1:0] left_out;
        logic signed [drl_pkg::CMD_W-1:0] right_out;
        logic                             adjusted;
    } t_res;

    logic [drl_pkg::LIM_W-1:0] r_min_mag;
    logic [drl_pkg::LIM_W-1:0] r_max_mag;

    logic               r_s1_v, r_s2_v, r_out_v;
    t_s1                r_s1, n_s1;
    drl_pkg::t_div_item r_s2, n_s2;
    t_res               r_out, n_out;

    logic               adv_s1, adv_s2, adv_out;
    logic               div_in_ready, div_out_valid;
    drl_pkg::t_div_item div_out;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mag <= drl_pkg::MIN_MAG_RESET;
            r_max_mag <= drl_pkg::MAX_MAG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                drl_pkg::REG_MIN_MAG: r_min_mag <= i_cfg.data;
                drl_pkg::REG_MAX_MAG: r_max_mag <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage handshake, from the output back to the input
    assign adv_out     = !r_out_v || o_res.ready;
    assign adv_s2      = !r_s2_v || div_in_ready;
    assign adv_s1      = !r_s1_v || adv_s2;
    assign i_cmd.ready = adv_s1;

    // Decode: pick the side that moves to the limit
    always_comb begin
        logic [drl_pkg::MAG_W-1:0] al, ar, m17;
        logic [drl_pkg::LIM_W-1:0] m;
        logic                      pick_l, pick_r, side_neg;
        al  = drl_pkg::mag(i_cmd.left_in);
        ar  = drl_pkg::mag(i_cmd.right_in);
        m   = (i_cmd.op == drl_pkg::OP_CEILING) ? r_max_mag : r_min_mag;
        m17 = drl_pkg::MAG_W'(m);
        if (i_cmd.op == drl_pkg::OP_FLOOR) begin
            pick_l = (al <= ar) && (i_cmd.left_in != '0) && (al < m17);
            pick_r = (ar < al) && (i_cmd.right_in != '0) && (ar < m17);
        end else begin
            pick_l = (al >= ar) && (al > m17);
            pick_r = (ar > al) && (ar > m17);
        end
        side_neg            = pick_l ? i_cmd.left_in[drl_pkg::CMD_W-1]
                                     : i_cmd.right_in[drl_pkg::CMD_W-1];
        n_s1.pass.adj       = pick_l || pick_r;
        n_s1.pass.pick_left = pick_l;
        n_s1.pass.fix       = side_neg ? drl_pkg::CMD_W'(16'd0 - 16'(m)) : 16'(m);
        n_s1.pass.left      = i_cmd.left_in;
        n_s1.pass.right     = i_cmd.right_in;
        n_s1.other_mag      = pick_l ? ar : al;
        n_s1.side_mag       = pick_l ? al : ar;
        n_s1.lim            = m;
        n_s1.neg            = pick_l ? i_cmd.right_in[drl_pkg::CMD_W-1]
                                     : i_cmd.left_in[drl_pkg::CMD_W-1];
    end

    // Multiply: |other| * limit
    always_comb begin
        n_s2.rem  = drl_pkg::PROD_W'(drl_pkg::PROD_W'(r_s1.other_mag)
                                     * drl_pkg::PROD_W'(r_s1.lim));
        n_s2.dvsr = r_s1.side_mag;
        n_s2.quo  = '0;
        n_s2.ovf  = 1'b0;
        n_s2.neg  = r_s1.neg;
        n_s2.pass = r_s1.pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (adv_s1) r_s1_v <= i_cmd.valid;
            if (adv_s2) r_s2_v <= r_s1_v;
        end
        if (adv_s1) r_s1 <= n_s1;
        if (adv_s2) r_s2 <= n_s2;
    end

    drl_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .o_ready (div_in_ready),
        .i_item  (r_s2),
        .o_valid (div_out_valid),
        .i_ready (adv_out),
        .o_item  (div_out)
    );

    // Apply sign, saturate and put the pair back together
    always_comb begin
        logic [drl_pkg::QUO_W:0]          q;
        logic signed [drl_pkg::CMD_W-1:0] scaled;
        q = {1'b0, div_out.quo};
        if (div_out.neg) begin
            if (div_out.ovf || q > drl_pkg::NEG_LIMIT) begin
                scaled = {1'b1, {(drl_pkg::CMD_W-1){1'b0}}};
            end else begin
                scaled = drl_pkg::CMD_W'(17'd0 - q);
            end
        end else begin
            if (div_out.ovf || q > drl_pkg::POS_LIMIT) begin
                scaled = {1'b0, {(drl_pkg::CMD_W-1){1'b1}}};
            end else begin
                scaled = drl_pkg::CMD_W'(q);
            end
        end
        n_out.adjusted = div_out.pass.adj;
        if (!div_out.pass.adj) begin
            n_out.left_out  = div_out.pass.left;
            n_out.right_out = div_out.pass.right;
        end else if (div_out.pass.pick_left) begin
            n_out.left_out  = div_out.pass.fix;
            n_out.right_out = scaled;
        end else begin
            n_out.left_out  = scaled;
            n_out.right_out = div_out.pass.fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv_out) begin
            r_out_v <= div_out_valid;
        end
        if (adv_out) r_out <= n_out;
    end

    assign o_res.valid     = r_out_v;
    assign o_res.left_out  = r_out.left_out;
    assign o_res.right_out = r_out.right_out;
    assign o_res.adjusted  = r_out.adjusted;

endmodule
